>>> src/rnc_pkg.sv
`timescale 1ns / 1ps

package rnc_pkg;

  // Width of the value field on the result side
  localparam int unsigned VALUE_W = 31;

  localparam logic [7:0] ASCII_ZERO    = 8'd48;
  localparam logic [7:0] ASCII_NINE    = 8'd57;
  localparam logic [7:0] ASCII_UP_A    = 8'd65;
  localparam logic [7:0] ASCII_UP_F    = 8'd70;
  localparam logic [7:0] ASCII_LO_A    = 8'd97;
  localparam logic [7:0] ASCII_LO_F    = 8'd102;
  localparam logic [7:0] UP_ALPHA_OFS  = 8'd55;
  localparam logic [7:0] LO_ALPHA_OFS  = 8'd87;

  localparam logic [4:0] BASE_DEC     = 5'd10;
  localparam logic [4:0] BASE_BIN     = 5'd2;
  localparam logic [4:0] BASE_OCT     = 5'd8;
  localparam logic [4:0] BASE_HEX     = 5'd16;
  localparam logic [4:0] DIGIT_BAD    = 5'd16;

  typedef enum logic [1:0] {
    REQ_DEC = 2'd0,
    REQ_BIN = 2'd1,
    REQ_OCT = 2'd2,
    REQ_HEX = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_DIGIT    = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    OB_BIN = 2'd0,
    OB_OCT = 2'd1,
    OB_HEX = 2'd2
  } out_base_t;

  typedef enum logic {
    KIND_VALUE = 1'b0,
    KIND_DIGIT = 1'b1
  } item_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_VALUE,
    BK_DIGITS
  } back_state_t;

  typedef struct packed {
    logic               item_kind;
    logic [VALUE_W-1:0] value;
    logic [1:0]         error_code;
    logic [1:0]         out_base;
    logic [7:0]         digit_char;
    logic               last_result;
  } item_t;

endpackage

>>> src/radix_number_converter_unit.sv
`timescale 1ns / 1ps

// Radix number converter.
// Input queue: one ASCII digit per word (in_char_code), its base in in_req_type
// (decimal, binary, octal, hex; hex takes either letter case) and in_last_char
// on the final digit. A word is taken when in_push is high and in_full is low.
// Digits accumulate as value * base + digit, one word per cycle unless in_full.
// Result queue: while out_empty is low the oldest result word is on the out_
// ports; out_pop takes it. After the last digit comes one value word (value and
// error code), then, if the value is nonzero and error free, its digits MSB
// first in binary, octal and uppercase hex, out_last_result on the final word.
// The last digit passes through the number queue, then the back end's idle and
// value states, before the value word is registered on the out_ ports. Digit
// words follow at one per cycle while the receiver keeps popping; each leading
// zero position takes a step that gives no word. A two-entry queue of finished
// numbers lets characters keep flowing while digits go out; in_full rises only
// when it holds two numbers. A stalled receiver just holds the current word.
// Reset clears the accumulator, the error, the number queue and the output
// valid flag; the output word's fields are not reset.
module radix_number_converter_unit #(
  parameter int unsigned VALUE_BITS = 31
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [7:0]                  in_char_code,
  input  logic [1:0]                  in_req_type,
  input  logic                        in_last_char,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic                        out_item_kind,
  output logic [rnc_pkg::VALUE_W-1:0] out_value,
  output logic [1:0]                  out_error_code,
  output logic [1:0]                  out_out_base,
  output logic [7:0]                  out_digit_char,
  output logic                        out_last_result
);

  localparam int unsigned JW = VALUE_BITS + 2;

  logic                  job_push, job_full, job_pop, job_empty;
  logic [VALUE_BITS-1:0] push_value;
  logic [1:0]            push_err;
  logic [JW-1:0]         job_din, job_dout;
  logic                  out_valid;
  rnc_pkg::item_t        out_item;

  rnc_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_char_code (in_char_code),
    .in_req_type  (in_req_type),
    .in_last_char (in_last_char),
    .job_push     (job_push),
    .job_value    (push_value),
    .job_err      (push_err),
    .job_full     (job_full)
  );

  assign job_din = {push_err, push_value};

  rnc_job_fifo #(.WIDTH(JW)) u_job_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .din   (job_din),
    .full  (job_full),
    .pop   (job_pop),
    .dout  (job_dout),
    .empty (job_empty)
  );

  rnc_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job_value (job_dout[VALUE_BITS-1:0]),
    .job_err   (job_dout[JW-1:VALUE_BITS]),
    .job_pop   (job_pop),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_pop   (out_pop)
  );

  assign out_empty       = !out_valid;
  assign out_item_kind   = out_item.item_kind;
  assign out_value       = out_item.value;
  assign out_error_code  = out_item.error_code;
  assign out_out_base    = out_item.out_base;
  assign out_digit_char  = out_item.digit_char;
  assign out_last_result = out_item.last_result;

endmodule

>>> src/rnc_job_fifo.sv
`timescale 1ns / 1ps

// Two-entry queue of finished numbers between front and back
module rnc_job_fifo #(
  parameter int unsigned WIDTH = 33
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign dout    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

>>> src/rnc_front.sv
`timescale 1ns / 1ps

// Accumulates characters of one number; hands the finished number to the queue
module rnc_front #(
  parameter int unsigned VALUE_BITS = 31
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [7:0]            in_char_code,
  input  logic [1:0]            in_req_type,
  input  logic                  in_last_char,
  output logic                  job_push,
  output logic [VALUE_BITS-1:0] job_value,
  output logic [1:0]            job_err,
  input  logic                  job_full
);

  localparam int unsigned PW = VALUE_BITS + 5;

  logic [VALUE_BITS-1:0] acc_r, acc_nxt, acc_upd;
  logic [1:0]            err_r, err_nxt, err_upd;
  logic [4:0]            dig;
  logic [4:0]            base;
  logic [7:0]            ofs;
  logic [PW-1:0]         acc_w, prod, sum;
  logic                  is_hex, ovf, accept;

  assign in_full = job_full;
  assign accept  = in_push && !job_full;
  assign is_hex  = (in_req_type == rnc_pkg::REQ_HEX);
  assign acc_w   = PW'(acc_r);

  always_comb begin
    ofs = 8'd0;
    dig = rnc_pkg::DIGIT_BAD;
    if (in_char_code >= rnc_pkg::ASCII_ZERO && in_char_code <= rnc_pkg::ASCII_NINE) begin
      ofs = in_char_code - rnc_pkg::ASCII_ZERO;
      dig = ofs[4:0];
    end else if (is_hex && in_char_code >= rnc_pkg::ASCII_UP_A &&
                 in_char_code <= rnc_pkg::ASCII_UP_F) begin
      ofs = in_char_code - rnc_pkg::UP_ALPHA_OFS;
      dig = ofs[4:0];
    end else if (is_hex && in_char_code >= rnc_pkg::ASCII_LO_A &&
                 in_char_code <= rnc_pkg::ASCII_LO_F) begin
      ofs = in_char_code - rnc_pkg::LO_ALPHA_OFS;
      dig = ofs[4:0];
    end
  end

  always_comb begin
    unique case (in_req_type)
      rnc_pkg::REQ_DEC: begin
        base = rnc_pkg::BASE_DEC;
        prod = (acc_w << 3) + (acc_w << 1);
      end
      rnc_pkg::REQ_BIN: begin
        base = rnc_pkg::BASE_BIN;
        prod = acc_w << 1;
      end
      rnc_pkg::REQ_OCT: begin
        base = rnc_pkg::BASE_OCT;
        prod = acc_w << 3;
      end
      default: begin
        base = rnc_pkg::BASE_HEX;
        prod = acc_w << 4;
      end
    endcase
  end

  assign sum = prod + PW'(dig);
  // any bit above the value width means the number no longer fits
  assign ovf = |sum[PW-1:VALUE_BITS];

  always_comb begin
    acc_upd = acc_r;
    err_upd = err_r;
    if (err_r == rnc_pkg::ERR_NONE) begin
      priority if (dig >= base) begin
        err_upd = rnc_pkg::ERR_DIGIT;
      end else if (ovf) begin
        err_upd = rnc_pkg::ERR_OVERFLOW;
      end else begin
        acc_upd = sum[VALUE_BITS-1:0];
      end
    end
  end

  always_comb begin
    acc_nxt  = acc_r;
    err_nxt  = err_r;
    job_push = 1'b0;
    if (accept) begin
      if (in_last_char) begin
        job_push = 1'b1;
        acc_nxt  = '0;
        err_nxt  = rnc_pkg::ERR_NONE;
      end else begin
        acc_nxt = acc_upd;
        err_nxt = err_upd;
      end
    end
  end

  assign job_value = acc_upd;
  assign job_err   = err_upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      err_r <= rnc_pkg::ERR_NONE;
    end else begin
      acc_r <= acc_nxt;
      err_r <= err_nxt;
    end
  end

endmodule

>>> src/rnc_back.sv
`timescale 1ns / 1ps

// Turns one finished number into its result words; owns the output register
module rnc_back #(
  parameter int unsigned VALUE_BITS = 31
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  job_empty,
  input  logic [VALUE_BITS-1:0] job_value,
  input  logic [1:0]            job_err,
  output logic                  job_pop,
  output logic                  out_valid,
  output rnc_pkg::item_t        out_item,
  input  logic                  out_pop
);

  localparam int unsigned WPAD   = VALUE_BITS + 3;
  localparam int unsigned ND_BIN = VALUE_BITS;
  localparam int unsigned ND_OCT = (VALUE_BITS + 2) / 3;
  localparam int unsigned ND_HEX = (VALUE_BITS + 3) / 4;
  localparam int unsigned SH_BIN = WPAD - ND_BIN;
  localparam int unsigned SH_OCT = WPAD - 3 * ND_OCT;
  localparam int unsigned SH_HEX = WPAD - 4 * ND_HEX;
  localparam int unsigned CW     = $clog2(VALUE_BITS + 1);

  rnc_pkg::back_state_t state_r, state_nxt;

  logic [VALUE_BITS-1:0]       val_r;
  logic [1:0]                  err_r;
  logic [1:0]                  grp_r, grp_nxt;
  logic [WPAD-1:0]             sh_r, sh_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic                        started_r, started_nxt;
  logic                        out_valid_r, out_valid_nxt;
  rnc_pkg::item_t              item_r, item_nxt;

  logic                        adv, emit, grp_done, no_digits;
  logic [3:0]                  dig;
  logic [7:0]                  dchar;
  logic [WPAD-1:0]             val_ext;
  logic [VALUE_BITS+rnc_pkg::VALUE_W-1:0] val_wide;

  assign adv       = !out_valid_r || out_pop;
  assign val_ext   = WPAD'(val_r);
  assign val_wide  = {{rnc_pkg::VALUE_W{1'b0}}, val_r};
  assign no_digits = (err_r != rnc_pkg::ERR_NONE) || (val_r == '0);
  assign grp_done  = (cnt_r == CW'(1));
  assign out_valid = out_valid_r;
  assign out_item  = item_r;

  always_comb begin
    unique case (grp_r)
      rnc_pkg::OB_BIN: dig = {3'b000, sh_r[WPAD-1]};
      rnc_pkg::OB_OCT: dig = {1'b0, sh_r[WPAD-1 -: 3]};
      default:         dig = sh_r[WPAD-1 -: 4];
    endcase
  end

  assign dchar = (dig < 4'd10) ? (rnc_pkg::ASCII_ZERO + 8'(dig))
                               : (rnc_pkg::UP_ALPHA_OFS + 8'(dig));
  // leading zero positions are stepped over without a word
  assign emit  = started_r || (dig != 4'd0);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rnc_pkg::BK_IDLE: begin
        if (!job_empty) state_nxt = rnc_pkg::BK_VALUE;
      end
      rnc_pkg::BK_VALUE: begin
        if (adv) state_nxt = no_digits ? rnc_pkg::BK_IDLE : rnc_pkg::BK_DIGITS;
      end
      rnc_pkg::BK_DIGITS: begin
        if (adv && grp_done && grp_r == rnc_pkg::OB_HEX) state_nxt = rnc_pkg::BK_IDLE;
      end
      default: state_nxt = rnc_pkg::BK_IDLE;
    endcase
  end

  // datapath and output word
  always_comb begin
    job_pop       = 1'b0;
    grp_nxt       = grp_r;
    sh_nxt        = sh_r;
    cnt_nxt       = cnt_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r && !out_pop;
    item_nxt      = item_r;
    unique case (state_r)
      rnc_pkg::BK_IDLE: begin
        job_pop = !job_empty;
      end
      rnc_pkg::BK_VALUE: begin
        if (adv) begin
          out_valid_nxt        = 1'b1;
          item_nxt             = '0;
          item_nxt.item_kind   = rnc_pkg::KIND_VALUE;
          item_nxt.value       = (err_r != rnc_pkg::ERR_NONE) ? '0
                                 : val_wide[rnc_pkg::VALUE_W-1:0];
          item_nxt.error_code  = err_r;
          item_nxt.last_result = no_digits;
          grp_nxt              = rnc_pkg::OB_BIN;
          sh_nxt               = val_ext << SH_BIN;
          cnt_nxt              = CW'(ND_BIN);
          started_nxt          = 1'b0;
        end
      end
      rnc_pkg::BK_DIGITS: begin
        if (adv) begin
          if (emit) begin
            out_valid_nxt        = 1'b1;
            item_nxt             = '0;
            item_nxt.item_kind   = rnc_pkg::KIND_DIGIT;
            item_nxt.out_base    = grp_r;
            item_nxt.digit_char  = dchar;
            item_nxt.last_result = grp_done && (grp_r == rnc_pkg::OB_HEX);
          end
          if (grp_done) begin
            started_nxt = 1'b0;
            if (grp_r == rnc_pkg::OB_BIN) begin
              grp_nxt = rnc_pkg::OB_OCT;
              sh_nxt  = val_ext << SH_OCT;
              cnt_nxt = CW'(ND_OCT);
            end else begin
              grp_nxt = rnc_pkg::OB_HEX;
              sh_nxt  = val_ext << SH_HEX;
              cnt_nxt = CW'(ND_HEX);
            end
          end else begin
            started_nxt = emit;
            cnt_nxt     = cnt_r - CW'(1);
            unique case (grp_r)
              rnc_pkg::OB_BIN: sh_nxt = sh_r << 1;
              rnc_pkg::OB_OCT: sh_nxt = sh_r << 3;
              default:         sh_nxt = sh_r << 4;
            endcase
          end
        end
      end
      default: job_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rnc_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      started_r   <= started_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      val_r <= job_value;
      err_r <= job_err;
    end
    grp_r  <= grp_nxt;
    sh_r   <= sh_nxt;
    cnt_r  <= cnt_nxt;
    item_r <= item_nxt;
  end

endmodule
